FILE: sv/utf8d_pkg.sv
package utf8d_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned MAX_RES = 4;
  localparam int unsigned HOLD_D  = 3;

  localparam logic [CP_W-1:0] CP_MIN2 = 21'h00080;
  localparam logic [CP_W-1:0] CP_MIN3 = 21'h00800;
  localparam logic [CP_W-1:0] CP_MIN4 = 21'h10000;
  localparam logic [CP_W-1:0] CP_MAX  = 21'h10FFFF;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_2    = 3'd2;
  localparam logic [2:0] LEN_3    = 3'd3;
  localparam logic [2:0] LEN_4    = 3'd4;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_text;
  } in_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            raw_fallback;
    logic            last_of_run;
  } out_t;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            raw_fallback;
  } res_t;

  typedef struct packed {
    res_t [MAX_RES-1:0] ent;
    logic [2:0]         num;
  } bundle_t;

  typedef struct packed {
    logic [1:0] cnt;
    logic [2:0] len;
  } state_t;

endpackage

FILE: sv/utf8d_decode.sv
module utf8d_decode (
  input  utf8d_pkg::in_t                                     in_data_i,
  input  logic [utf8d_pkg::HOLD_D-1:0][utf8d_pkg::BYTE_W-1:0] pend_i,
  input  utf8d_pkg::state_t                                  st_i,
  output logic [utf8d_pkg::HOLD_D-1:0][utf8d_pkg::BYTE_W-1:0] pend_o,
  output utf8d_pkg::state_t                                  st_o,
  output utf8d_pkg::bundle_t                                 bun_o
);

  logic [utf8d_pkg::BYTE_W-1:0] b;
  logic                         eot;
  logic                         is_cont;
  logic                         empty;
  logic                         complete;
  logic [2:0]                   lead_len;
  logic [utf8d_pkg::CP_W-1:0]   cp;
  logic                         ok;
  logic                         flush_old;
  logic                         tail_vld;
  utf8d_pkg::res_t              tail;
  logic [1:0]                   k;

  assign b        = in_data_i.data_byte;
  assign eot      = in_data_i.end_of_text;
  assign is_cont  = (b[7:6] == 2'b10);
  assign empty    = (st_i.cnt == 2'd0);
  assign complete = !empty && is_cont && (({1'b0, st_i.cnt} + 3'd1) == st_i.len);

  always_comb begin
    if (b[7:5] == 3'b110) begin
      lead_len = utf8d_pkg::LEN_2;
    end else if (b[7:4] == 4'b1110) begin
      lead_len = utf8d_pkg::LEN_3;
    end else if (b[7:3] == 5'b11110) begin
      lead_len = utf8d_pkg::LEN_4;
    end else begin
      lead_len = utf8d_pkg::LEN_NONE;
    end
  end

  always_comb begin
    case (st_i.len)
      utf8d_pkg::LEN_2: begin
        cp = {10'd0, pend_i[0][4:0], b[5:0]};
        ok = (cp >= utf8d_pkg::CP_MIN2);
      end
      utf8d_pkg::LEN_3: begin
        cp = {5'd0, pend_i[0][3:0], pend_i[1][5:0], b[5:0]};
        ok = (cp >= utf8d_pkg::CP_MIN3);
      end
      utf8d_pkg::LEN_4: begin
        cp = {pend_i[0][2:0], pend_i[1][5:0], pend_i[2][5:0], b[5:0]};
        ok = (cp >= utf8d_pkg::CP_MIN4) && (cp <= utf8d_pkg::CP_MAX);
      end
      default: begin
        cp = '0;
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    pend_o            = pend_i;
    st_o              = st_i;
    flush_old         = 1'b0;
    tail_vld          = 1'b0;
    tail.code_point   = {13'd0, b};
    tail.raw_fallback = 1'b1;
    if (empty || !is_cont) begin
      flush_old = !empty;
      if (lead_len == utf8d_pkg::LEN_NONE) begin
        tail_vld          = 1'b1;
        tail.raw_fallback = b[7];
        st_o              = '0;
      end else begin
        pend_o[0] = b;
        st_o.cnt  = 2'd1;
        st_o.len  = lead_len;
        tail_vld  = eot;
      end
    end else if (complete) begin
      st_o     = '0;
      tail_vld = 1'b1;
      if (ok) begin
        tail.code_point   = cp;
        tail.raw_fallback = 1'b0;
      end else begin
        flush_old = 1'b1;
      end
    end else begin
      pend_o[st_i.cnt] = b;
      st_o.cnt         = st_i.cnt + 2'd1;
      flush_old        = eot;
      tail_vld         = eot;
    end
    if (eot) begin
      st_o = '0;
    end
  end

  assign k = flush_old ? st_i.cnt : 2'd0;

  always_comb begin
    bun_o.num    = {1'b0, k} + {2'b00, tail_vld};
    bun_o.ent[0] = (k > 2'd0) ?
                   utf8d_pkg::res_t'{code_point: {13'd0, pend_i[0]}, raw_fallback: 1'b1} : tail;
    bun_o.ent[1] = (k > 2'd1) ?
                   utf8d_pkg::res_t'{code_point: {13'd0, pend_i[1]}, raw_fallback: 1'b1} : tail;
    bun_o.ent[2] = (k > 2'd2) ?
                   utf8d_pkg::res_t'{code_point: {13'd0, pend_i[2]}, raw_fallback: 1'b1} : tail;
    bun_o.ent[3] = tail;
  end

endmodule

FILE: sv/utf8_decoder_with_byte_fallback.sv
// The first result of a byte is registered in the result buffer, then in the output register.
// Throughput: one byte per cycle while each byte yields at most one result and the output is not
// stalled; a byte that yields n results (up to 4) holds the result buffer until all n have been sent.
// Reset (rst_ni low, asynchronous): no sequence held, result buffer and
// output register empty. Held sequence bytes are not cleared.
module utf8_decoder_with_byte_fallback (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  utf8d_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output utf8d_pkg::out_t   out_data_o
);

  logic [utf8d_pkg::HOLD_D-1:0][utf8d_pkg::BYTE_W-1:0] pend_q, pend_d;
  utf8d_pkg::state_t  st_q, st_d;
  utf8d_pkg::bundle_t bun_q, bun_d;
  logic               bun_valid_q;
  logic [1:0]         rd_q;
  utf8d_pkg::out_t    out_q;
  logic               out_valid_q;

  logic out_free;
  logic bun_move;
  logic bun_last;
  logic bun_done;
  logic in_fire;

  utf8d_decode u_decode (
    .in_data_i (in_data_i),
    .pend_i    (pend_q),
    .st_i      (st_q),
    .pend_o    (pend_d),
    .st_o      (st_d),
    .bun_o     (bun_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign bun_move   = bun_valid_q && out_free;
  assign bun_last   = ({1'b0, rd_q} == (bun_q.num - 3'd1));
  assign bun_done   = bun_move && bun_last;
  assign in_ready_o = !bun_valid_q || bun_done;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      bun_valid_q <= 1'b0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        st_q        <= st_d;
        bun_valid_q <= (bun_d.num != 3'd0);
        rd_q        <= '0;
      end else if (bun_done) begin
        bun_valid_q <= 1'b0;
      end else if (bun_move) begin
        rd_q <= rd_q + 2'd1;
      end
      if (bun_move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      pend_q <= pend_d;
      bun_q  <= bun_d;
    end
    if (bun_move) begin
      out_q.code_point   <= bun_q.ent[rd_q].code_point;
      out_q.raw_fallback <= bun_q.ent[rd_q].raw_fallback;
      out_q.last_of_run  <= bun_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_hold_shorter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.cnt != 2'd0) |-> ({1'b0, st_q.cnt} < st_q.len))
    else $error("held byte count not below sequence length");

  a_bundle_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bun_valid_q |-> ((bun_q.num != 3'd0) && ({1'b0, rd_q} < bun_q.num)))
    else $error("result buffer index out of range");

  a_eot_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.end_of_text) |=> (st_q.cnt == 2'd0))
    else $error("sequence still held after final byte");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int STALL_LIMIT = 1000;
  localparam int CALM_TAIL   = 30;

  typedef struct packed {
    utf8d_pkg::in_t beat;
    logic           hold;
  } pend_beat_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  utf8d_pkg::in_t  in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  utf8d_pkg::out_t out_data;

  utf8_decoder_with_byte_fallback dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  pend_beat_t      byte_q[$];
  utf8d_pkg::out_t cp_expect_q[$];
  utf8d_pkg::out_t run_q[$];

  // decoder shadow state
  logic [7:0] held [utf8d_pkg::HOLD_D];
  logic [1:0] held_cnt = '0;
  logic [2:0] seq_len = utf8d_pkg::LEN_NONE;

  bit calm = 1'b0;
  int send_gap = 0;
  int take_gap = 0;
  int stall_cnt = 0;
  int n_sent = 0;
  int n_res = 0;
  int n_miss = 0;
  int n_raw = 0;
  int n_multi = 0;
  int n_eot = 0;

  function automatic void put_cp(logic [utf8d_pkg::CP_W-1:0] cp, logic raw);
    utf8d_pkg::out_t r;
    r.code_point   = cp;
    r.raw_fallback = raw;
    r.last_of_run  = 1'b0;
    run_q.push_back(r);
  endfunction

  function automatic void flush_held();
    for (int i = 0; i < held_cnt; i++) put_cp({13'd0, held[i]}, 1'b1);
    held_cnt = '0;
    seq_len  = utf8d_pkg::LEN_NONE;
  endfunction

  function automatic void start_seq(logic [7:0] b);
    if (b[7] == 1'b0) begin
      put_cp({13'd0, b}, 1'b0);
      return;
    end
    if (b[7:5] == 3'b110) seq_len = utf8d_pkg::LEN_2;
    else if (b[7:4] == 4'b1110) seq_len = utf8d_pkg::LEN_3;
    else if (b[7:3] == 5'b11110) seq_len = utf8d_pkg::LEN_4;
    else begin
      put_cp({13'd0, b}, 1'b1);
      return;
    end
    held[0]  = b;
    held_cnt = 2'd1;
  endfunction

  function automatic void predict_byte(utf8d_pkg::in_t beat);
    logic [7:0]                b;
    logic [utf8d_pkg::CP_W-1:0] cp;
    logic                      ok;
    utf8d_pkg::out_t           r;
    b = beat.data_byte;
    run_q.delete();
    if (held_cnt == 0) begin
      seq_len = utf8d_pkg::LEN_NONE;
      start_seq(b);
    end else if (b[7:6] != 2'b10) begin
      flush_held();
      start_seq(b);
    end else if (held_cnt + 1 == seq_len) begin
      if (seq_len == utf8d_pkg::LEN_2) begin
        cp = {10'd0, held[0][4:0], b[5:0]};
        ok = cp >= utf8d_pkg::CP_MIN2;
      end else if (seq_len == utf8d_pkg::LEN_3) begin
        cp = {5'd0, held[0][3:0], held[1][5:0], b[5:0]};
        ok = cp >= utf8d_pkg::CP_MIN3;
      end else begin
        cp = {held[0][2:0], held[1][5:0], held[2][5:0], b[5:0]};
        ok = cp >= utf8d_pkg::CP_MIN4 && cp <= utf8d_pkg::CP_MAX;
      end
      if (ok) begin
        put_cp(cp, 1'b0);
        held_cnt = '0;
        seq_len  = utf8d_pkg::LEN_NONE;
      end else begin
        flush_held();
        put_cp({13'd0, b}, 1'b1);
      end
    end else begin
      held[held_cnt] = b;
      held_cnt++;
    end
    if (beat.end_of_text && held_cnt != 0) flush_held();
    if (run_q.size() > 0) begin
      r = run_q.pop_back();
      r.last_of_run = 1'b1;
      run_q.push_back(r);
    end
    foreach (run_q[i]) cp_expect_q.push_back(run_q[i]);
  endfunction

  function automatic void add_beat(logic [7:0] b, logic eot);
    pend_beat_t p;
    p.beat.data_byte   = b;
    p.beat.end_of_text = eot;
    p.hold             = 1'b0;
    byte_q.push_back(p);
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  function automatic logic eot_pick();
    return $urandom_range(0, 24) == 0;
  endfunction

  function automatic void log_miss(string what, utf8d_pkg::out_t want,
                                   utf8d_pkg::out_t got);
    n_miss++;
    if (n_miss <= 10)
      $display("ERROR %s: expected cp=%06h raw=%0b last=%0b, got cp=%06h raw=%0b last=%0b",
               what, want.code_point, want.raw_fallback, want.last_of_run,
               got.code_point, got.raw_fallback, got.last_of_run);
  endfunction

  // driver
  always @(posedge clk_i) begin
    logic           took;
    logic           nxt_valid;
    utf8d_pkg::in_t nxt_data;
    pend_beat_t     p;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
    end else begin
      took      = in_valid && in_ready;
      nxt_valid = in_valid && !took;
      nxt_data  = in_data;
      calm      = byte_q.size() < CALM_TAIL;
      if (took) begin
        predict_byte(in_data);
        n_sent++;
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (byte_q.size() > 0 && !(byte_q[0].hold && cp_expect_q.size() != 0)) begin
          if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 2);
          end else begin
            p         = byte_q.pop_front();
            nxt_valid = 1'b1;
            nxt_data  = p.beat;
          end
        end
      end
      in_valid <= nxt_valid;
      in_data  <= nxt_data;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    utf8d_pkg::out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_res++;
        if (cp_expect_q.size() == 0) begin
          want = '0;
          log_miss("unexpected beat", want, out_data);
        end else begin
          want = cp_expect_q.pop_front();
          if (out_data.code_point !== want.code_point ||
              out_data.raw_fallback !== want.raw_fallback ||
              out_data.last_of_run !== want.last_of_run)
            log_miss("beat differs", want, out_data);
          if (want.raw_fallback) n_raw++;
          else if (want.code_point >= utf8d_pkg::CP_MIN2) n_multi++;
        end
      end
      if (take_gap > 0) begin
        take_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        take_gap = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results outstanding",
               stall_cnt, cp_expect_q.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int         total;
    int         kind;
    int         len;
    int         cut;
    int         mark;
    int         n_rand;
    logic [7:0] lead;

    // directed: extremes, every lead class, fallback paths
    add_beat(8'h00, 1'b0);
    add_beat(8'h7F, 1'b0);
    add_beat(8'hDF, 1'b0); add_beat(8'hBF, 1'b0);
    add_beat(8'hC1, 1'b0); add_beat(8'hBF, 1'b0);
    add_beat(8'hED, 1'b0); add_beat(8'hA0, 1'b0); add_beat(8'h80, 1'b0);
    add_beat(8'hF4, 1'b0); add_beat(8'h8F, 1'b0); add_beat(8'hBF, 1'b0); add_beat(8'hBF, 1'b0);
    add_beat(8'hF4, 1'b0); add_beat(8'h90, 1'b0); add_beat(8'h80, 1'b0); add_beat(8'h80, 1'b0);
    add_beat(8'h80, 1'b0);
    add_beat(8'hFF, 1'b0);
    add_beat(8'hF8, 1'b0);
    add_beat(8'hE2, 1'b0); add_beat(8'h41, 1'b0);
    add_beat(8'hF0, 1'b0); add_beat(8'h9F, 1'b1);
    add_beat(8'h41, 1'b1);

    n_rand = 0;
    while (n_rand < 205) begin
      mark = byte_q.size();
      kind = $urandom_range(0, 11);
      case (kind)
        0, 1: begin
          add_beat(8'($urandom_range(0, 127)), eot_pick());
        end
        2, 3, 4, 5, 6, 7: begin
          len = $urandom_range(2, 4);
          if (len == 2) lead = 8'hC0 | 8'($urandom_range(0, 31));
          else if (len == 3) lead = 8'hE0 | 8'($urandom_range(0, 15));
          else if ($urandom_range(0, 3) == 0) lead = 8'hF0 | 8'($urandom_range(0, 7));
          else lead = 8'hF0 | 8'($urandom_range(0, 4));
          cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len - 1) : len;
          add_beat(lead, eot_pick());
          for (int i = 1; i < cut; i++) add_beat(cont_byte(), eot_pick());
        end
        8: begin
          add_beat(8'($urandom_range(0, 255)), eot_pick());
        end
        9: begin
          add_beat(cont_byte(), eot_pick());
        end
        default: begin
          len = $urandom_range(1, 4);
          for (int i = 0; i < len; i++)
            add_beat(8'($urandom_range(0, 127)), i == len - 1);
        end
      endcase
      if (n_rand == 0 || $urandom_range(0, 39) == 0) byte_q[mark].hold = 1'b1;
      n_rand += byte_q.size() - mark;
    end

    total = byte_q.size();
    foreach (byte_q[i]) if (byte_q[i].beat.end_of_text) n_eot++;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (n_sent < total || cp_expect_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Fed %0d bytes (%0d text ends); checked %0d results", n_sent, n_eot, n_res);
    $display("  of which %0d multibyte code points and %0d raw fallback bytes", n_multi, n_raw);
    if (n_miss == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

FILE: utf8_decoder_with_byte_fallback.f
sv/utf8d_pkg.sv
sv/utf8d_decode.sv
sv/utf8_decoder_with_byte_fallback.sv
dv/tb.sv
